// ----- hdl/fbpa_pkg.sv -----
// fbpa_pkg: shared types, codes and constants of the fixed block pool allocator
// no dependencies; imported by fbpa_decode, fixed_block_pool_allocator and the testbench

package fbpa_pkg;

  // fixed field widths
  localparam int ADDR_W   = 32;
  localparam int SIZE_W   = 16;
  localparam int GUARD_W  = 8;
  localparam int CNT_W    = 9;
  localparam int STRIDE_W = 17;  // block size plus two guard areas
  localparam int POS_W    = 8;
  localparam int CFG_IDX_W = 2;

  // parameter defaults
  localparam int DEF_NUM_BLOCKS   = 256;
  localparam int DEF_ADDRESS_BITS = 32;

  // register reset values
  localparam logic [ADDR_W-1:0]  RST_FIRST_ADDR = '0;
  localparam logic [SIZE_W-1:0]  RST_BLOCK_SIZE = 16'd16;
  localparam logic [GUARD_W-1:0] RST_GUARD      = '0;
  localparam logic [CNT_W-1:0]   RST_BLOCKS     = 9'd256;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS     = 2'd3;

  // operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;
  localparam logic [1:0] OP_FIND  = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_BLOCK = 2'd2;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] result_address;
    logic              is_block;
    logic              found;
    logic [POS_W-1:0]  list_position;
  } rsp_t;

  // address decoder status toward the control fsm
  typedef struct packed {
    logic done;
    logic is_block;
  } dec_status_t;

endpackage

// ----- hdl/fbpa_ram.sv -----
// fbpa_ram: generic single write port, single read port ram with registered read
// no dependencies

module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/fbpa_decode.sv -----
// fbpa_decode: maps a byte address to a block index, bit-serial restoring division
// depends on fbpa_pkg

module fbpa_decode
  import fbpa_pkg::*;
#(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ADDR_W-1:0]             address,
  input  logic [ADDR_W-1:0]             first_addr,
  input  logic [STRIDE_W-1:0]           stride,
  input  logic [CNT_W-1:0]              count,
  output dec_status_t                   st,
  output logic [$clog2(NUM_BLOCKS)-1:0] idx
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int Q_W   = (IDX_W < CNT_W) ? IDX_W : CNT_W;
  localparam int REM_W = STRIDE_W + CNT_W;
  localparam int DSR_W = STRIDE_W + Q_W - 1;
  localparam int IT_W  = (Q_W > 1) ? $clog2(Q_W) : 1;

  typedef enum logic [1:0] {D_IDLE, D_CMP, D_DIV} dstate_t;

  dstate_t            dstate;
  logic [ADDR_W-1:0]  off;
  logic               below;
  logic [REM_W-1:0]   limit;
  logic [REM_W-1:0]   rem;
  logic [REM_W-1:0]   rem_next;
  logic               rem_ge;
  logic [DSR_W-1:0]   dsr;
  logic [Q_W-1:0]     q;
  logic [Q_W-1:0]     q_next;
  logic [IT_W-1:0]    it;

  always_comb begin
    rem_ge   = rem >= REM_W'(dsr);
    rem_next = rem_ge ? (rem - REM_W'(dsr)) : rem;
    q_next   = (q << 1) | Q_W'(rem_ge);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      st     <= '0;
    end else begin
      st.done <= 1'b0;
      unique case (dstate)
        D_IDLE: begin
          if (start) begin
            off    <= address - first_addr;
            below  <= address < first_addr;
            limit  <= REM_W'(stride) * REM_W'(count);
            dstate <= D_CMP;
          end
        end
        D_CMP: begin
          // outside the pool: below the base or past the last block
          if (below || off >= ADDR_W'(limit)) begin
            st.done     <= 1'b1;
            st.is_block <= 1'b0;
            dstate      <= D_IDLE;
          end else begin
            rem    <= off[REM_W-1:0];
            dsr    <= DSR_W'(stride) << (Q_W - 1);
            q      <= '0;
            it     <= IT_W'(Q_W - 1);
            dstate <= D_DIV;
          end
        end
        D_DIV: begin
          rem <= rem_next;
          q   <= q_next;
          dsr <= dsr >> 1;
          if (it == '0) begin
            st.done     <= 1'b1;
            st.is_block <= (rem_next == '0);
            idx         <= IDX_W'(q_next);
            dstate      <= D_IDLE;
          end else begin
            it <= it - IT_W'(1);
          end
        end
        default: dstate <= D_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/fixed_block_pool_allocator.sv -----
// fixed_block_pool_allocator: top level, control fsm, link store and register file
// depends on fbpa_pkg, fbpa_ram, fbpa_decode

// Pool of NUM_BLOCKS equal blocks at a stride of block_size + 2 * guard_bytes,
// managed as a LIFO free list held in a link ram (one next index per block) and
// a head register. One item is worked at a time. Allocate reads the head link,
// multiplies the head index by the stride and adds the first address; an empty
// pool goes straight to the response. Free, check and find run the address
// through a bit-serial divider; an address outside the pool skips the division.
// Find then walks the free list, one registered link ram read per link walked.
// After reset and after every blocks_in_use write the link ram is rebuilt by a
// clearing pass over all NUM_BLOCKS entries, during which req_stall stays high;
// register writes are taken as ever. A finished result waits in the output
// register while the next item is accepted.

module fixed_block_pool_allocator
  import fbpa_pkg::*;
#(
  parameter int NUM_BLOCKS   = DEF_NUM_BLOCKS,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  // item input channel
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  // result channel
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp,
  // register write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  localparam int IDX_W     = $clog2(NUM_BLOCKS);
  localparam int LINK_W    = $clog2(NUM_BLOCKS + 1);  // holds the end marker
  localparam int PROD_W    = IDX_W + STRIDE_W;
  localparam int MASK_BITS = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - MASK_BITS);

  typedef enum logic [2:0] {
    S_IDLE, S_ALLOC_RD, S_ALLOC_WB, S_DECODE, S_FIND_CHK, S_FIND_WAIT, S_RESP
  } state_t;

  // configuration registers
  logic [ADDR_W-1:0]   first_addr;
  logic [SIZE_W-1:0]   block_size;
  logic [GUARD_W-1:0]  guard;
  logic [CNT_W-1:0]    blocks_in_use;

  // derived config
  logic [STRIDE_W-1:0] stride;
  logic [CNT_W-1:0]    count;

  // control and list state
  state_t              state;
  logic [LINK_W-1:0]   head;
  logic                sweeping;
  logic [LINK_W-1:0]   sweep_cnt;
  logic [1:0]          op;
  rsp_t                res;
  logic [PROD_W-1:0]   prod;
  logic [LINK_W-1:0]   cur;
  logic [LINK_W-1:0]   steps;
  logic [31:0]         steps_wide;

  // link ram ports
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [LINK_W-1:0]   mem_wdata;
  logic [IDX_W-1:0]    mem_raddr;
  logic [LINK_W-1:0]   mem_rdata;

  // address decoder
  logic                dec_start;
  dec_status_t         dec_st;
  logic [IDX_W-1:0]    dec_idx;

  logic                req_take;
  logic                rebuild;

  // zero block size counts as one byte
  assign stride = STRIDE_W'((block_size == '0) ? SIZE_W'(1) : block_size)
                + STRIDE_W'({guard, 1'b0});
  // block count clamped to the pool size
  assign count = (32'(blocks_in_use) > 32'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                        : blocks_in_use;

  assign req_stall  = sweeping || (state != S_IDLE);
  assign req_take   = req_valid && !req_stall;
  assign dec_start  = req_take && (req.operation != OP_ALLOC);
  assign rebuild    = cfg_we && (cfg_index == REG_BLOCKS);
  assign steps_wide = 32'(steps);

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      first_addr    <= RST_FIRST_ADDR;
      block_size    <= RST_BLOCK_SIZE;
      guard         <= RST_GUARD;
      blocks_in_use <= RST_BLOCKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_ADDR: first_addr    <= cfg_data;
        REG_BLOCK_SIZE: block_size    <= cfg_data[SIZE_W-1:0];
        REG_GUARD:      guard         <= cfg_data[GUARD_W-1:0];
        REG_BLOCKS:     blocks_in_use <= cfg_data[CNT_W-1:0];
        default:        first_addr    <= first_addr;
      endcase
    end
  end

  // link ram: the clearing pass owns the write port while it runs, a good
  // free writes the old head into the freed block's link
  always_comb begin
    mem_we    = sweeping || (state == S_DECODE && dec_st.done && op == OP_FREE
                             && dec_st.is_block);
    mem_waddr = sweeping ? sweep_cnt[IDX_W-1:0] : dec_idx;
    mem_wdata = sweeping ? (sweep_cnt + LINK_W'(1)) : head;
    mem_raddr = (state == S_FIND_CHK) ? cur[IDX_W-1:0] : head[IDX_W-1:0];
  end

  fbpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NUM_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fbpa_decode #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_decode (
    .clk        (clk),
    .rst        (rst),
    .start      (dec_start),
    .address    (req.address),
    .first_addr (first_addr),
    .stride     (stride),
    .count      (count),
    .st         (dec_st),
    .idx        (dec_idx)
  );

  // control fsm
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      sweeping  <= 1'b1;
      sweep_cnt <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // clearing pass: entry i links to i + 1
      if (sweeping) begin
        if (sweep_cnt == LINK_W'(NUM_BLOCKS - 1)) begin
          sweeping <= 1'b0;
        end
        sweep_cnt <= sweep_cnt + LINK_W'(1);
      end

      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_take) begin
            op  <= req.operation;
            res <= '0;
            if (req.operation == OP_ALLOC) begin
              if (32'(head) >= 32'(count)) begin
                res.status <= ST_EMPTY;
                state      <= S_RESP;
              end else begin
                state <= S_ALLOC_RD;
              end
            end else begin
              state <= S_DECODE;
            end
          end
        end
        S_ALLOC_RD: begin
          // head link read is in flight
          prod  <= PROD_W'(head[IDX_W-1:0]) * PROD_W'(stride);
          state <= S_ALLOC_WB;
        end
        S_ALLOC_WB: begin
          head               <= mem_rdata;
          res.result_address <= (first_addr + ADDR_W'(prod)) & ADDR_MASK;
          state              <= S_RESP;
        end
        S_DECODE: begin
          if (dec_st.done) begin
            res.is_block <= dec_st.is_block;
            case (op)
              OP_FREE: begin
                if (dec_st.is_block) begin
                  head <= LINK_W'(dec_idx);
                end else begin
                  res.status <= ST_NOT_BLOCK;
                end
                state <= S_RESP;
              end
              OP_FIND: begin
                if (dec_st.is_block) begin
                  cur   <= head;
                  steps <= '0;
                  state <= S_FIND_CHK;
                end else begin
                  state <= S_RESP;
                end
              end
              default: state <= S_RESP;
            endcase
          end
        end
        S_FIND_CHK: begin
          // walk ends at the list end or after NUM_BLOCKS links
          if (steps == LINK_W'(NUM_BLOCKS) || 32'(cur) >= 32'(count)) begin
            state <= S_RESP;
          end else if (cur == LINK_W'(dec_idx)) begin
            res.found         <= 1'b1;
            res.list_position <= steps_wide[POS_W-1:0];
            state             <= S_RESP;
          end else begin
            state <= S_FIND_WAIT;
          end
        end
        S_FIND_WAIT: begin
          cur   <= mem_rdata;
          steps <= steps + LINK_W'(1);
          state <= S_FIND_CHK;
        end
        S_RESP: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // a block count write rebuilds the list from scratch
      if (rebuild) begin
        head      <= '0;
        sweeping  <= 1'b1;
        sweep_cnt <= '0;
      end
    end
  end

  // head is a block index or the end marker
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    32'(head) <= 32'(NUM_BLOCKS))
    else $error("list head beyond end marker");

  // a pop only follows a head inside the pool
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_ALLOC_WB |-> $past(32'(head) < 32'(count)))
    else $error("pop from an empty list");

  // decoder answers only while the fsm waits for it
  a_dec_done: assert property (@(posedge clk) disable iff (rst)
    dec_st.done |-> state == S_DECODE)
    else $error("decoder done outside decode wait");

  // a new result is only loaded from the response state
  a_rsp_load: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_RESP))
    else $error("result appeared outside response state");

endmodule

// ----- tb/testbench.sv -----
// testbench: self-checking bench for the fixed block pool allocator
// depends on fbpa_pkg and fixed_block_pool_allocator; predicts every result in-bench

module testbench;
  import fbpa_pkg::*;

  localparam int POOL_DEPTH    = DEF_NUM_BLOCKS;
  // longest legal quiet stretch: receiver hold-off, a full find walk, or the
  // clearing pass after a block count write
  localparam int IDLE_LIMIT    = 6000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;

  // one accepted item and the result it must produce
  typedef struct {
    req_t item;
    rsp_t want;
  } pending_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FIRST_ADDR;
  logic [ADDR_W-1:0]    cfg_data = '0;

  // in-bench copy of the pool registers and free list
  logic [ADDR_W-1:0]  pool_first;
  logic [SIZE_W-1:0]  pool_size;
  logic [GUARD_W-1:0] pool_guard;
  logic [CNT_W-1:0]   pool_blocks;
  logic [CNT_W-1:0]   free_link [POOL_DEPTH];
  logic [CNT_W-1:0]   free_head;

  pending_t          pending_responses[$];
  logic [ADDR_W-1:0] held_blocks[$];   // addresses handed out, candidates for free
  int unsigned       mismatch_count = 0;
  int unsigned       req_idle_pct = 0;
  int unsigned       rsp_stall_pct = 0;
  int unsigned       hold_requests = 0;
  int unsigned       holds_served = 0;
  int unsigned       hold_left = 0;
  int unsigned       idle_cycles = 0;

  fixed_block_pool_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // pool prediction
  // ---------------------------------------------------------------------------

  // counts above the pool depth are clamped
  function automatic logic [CNT_W-1:0] live_blocks();
    return (pool_blocks > POOL_DEPTH) ? CNT_W'(POOL_DEPTH) : pool_blocks;
  endfunction

  // zero block size behaves as one byte
  function automatic logic [63:0] block_stride();
    logic [63:0] usable;
    usable = (pool_size == '0) ? 64'd1 : 64'(pool_size);
    return usable + 64'(pool_guard) * 2;
  endfunction

  function automatic void rebuild_free_list();
    for (int i = 0; i < POOL_DEPTH; i++) free_link[i] = CNT_W'(i + 1);
    free_head = '0;
  endfunction

  // block start address, wrapping at the address width
  function automatic logic [ADDR_W-1:0] block_address(input logic [63:0] idx);
    return ADDR_W'(64'(pool_first) + idx * block_stride());
  endfunction

  // block index of an address, no wrap-around, end bound exclusive
  function automatic bit locate_block(input logic [ADDR_W-1:0] addr,
                                      output logic [CNT_W-1:0] idx);
    logic [ADDR_W-1:0] diff;
    logic [63:0]       offset;
    logic [63:0]       stride;
    stride = block_stride();
    idx = '0;
    if (addr < pool_first) return 1'b0;
    diff = addr - pool_first;
    offset = 64'(diff);
    if (offset % stride != 0) return 1'b0;
    if (offset / stride >= 64'(live_blocks())) return 1'b0;
    idx = CNT_W'(offset / stride);
    return 1'b1;
  endfunction

  // expected result of one item; updates the free list as the block does
  function automatic rsp_t predict_pool_response(input req_t item);
    rsp_t             r;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] cur;
    bit               hit;
    r = '0;
    r.status = ST_DONE;
    count = live_blocks();
    if (item.operation == OP_ALLOC) begin
      if (free_head >= count) begin
        r.status = ST_EMPTY;
      end else begin
        r.result_address = block_address(64'(free_head));
        free_head = free_link[free_head];
      end
    end else begin
      hit = locate_block(item.address, idx);
      r.is_block = hit;
      if (item.operation == OP_FREE) begin
        if (!hit) begin
          r.status = ST_NOT_BLOCK;
        end else begin
          free_link[idx] = free_head;
          free_head = idx;
        end
      end else if (item.operation == OP_FIND && hit) begin
        // bounded walk, so a looped list after a double free still ends
        cur = free_head;
        for (int steps = 0; steps < POOL_DEPTH && cur < count; steps++) begin
          if (cur == idx) begin
            r.found = 1'b1;
            r.list_position = POS_W'(steps);
            break;
          end
          cur = free_link[cur];
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // receiver side: random stall, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result checking against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    pending_t oldest;
    if (!rst && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
      if (pending_responses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("error: unexpected result, status %0d addr %h",
                   rsp.status, rsp.result_address);
      end else begin
        oldest = pending_responses.pop_front();
        if (rsp.status !== oldest.want.status ||
            rsp.result_address !== oldest.want.result_address ||
            rsp.is_block !== oldest.want.is_block ||
            rsp.found !== oldest.want.found ||
            rsp.list_position !== oldest.want.list_position) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: op %0d addr %h",
                     oldest.item.operation, oldest.item.address);
            $display("  expected status %0d addr %h block %b found %b pos %0d",
                     oldest.want.status, oldest.want.result_address,
                     oldest.want.is_block, oldest.want.found,
                     oldest.want.list_position);
            $display("  actual   status %0d addr %h block %b found %b pos %0d",
                     rsp.status, rsp.result_address, rsp.is_block, rsp.found,
                     rsp.list_position);
          end
        end
      end
    end
  end

  // watchdog: ends the run when no item moves on either channel for too long
  always @(posedge clk) begin
    if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** fixed_block_pool_allocator: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one item, wait for it to be taken, then queue its expected result
  task automatic request(input logic [1:0] op, input logic [ADDR_W-1:0] addr);
    req_t     item;
    pending_t entry;
    item.operation = op;
    item.address = addr;
    while ($urandom_range(99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (req_stall !== 1'b0);
    entry.item = item;
    entry.want = predict_pool_response(item);
    pending_responses.push_back(entry);
    if (op == OP_ALLOC && entry.want.status == ST_DONE)
      held_blocks.push_back(entry.want.result_address);
  endtask

  // stop offering and let every outstanding result arrive
  task automatic wait_quiet();
    req_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [ADDR_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      REG_FIRST_ADDR: pool_first = value;
      REG_BLOCK_SIZE: pool_size = value[SIZE_W-1:0];
      REG_GUARD:      pool_guard = value[GUARD_W-1:0];
      REG_BLOCKS: begin
        // count write rebuilds the list, so nothing is held any more
        pool_blocks = value[CNT_W-1:0];
        rebuild_free_list();
        held_blocks.delete();
      end
    endcase
    @(posedge clk);
  endtask

  // all four registers, only once the block is idle
  task automatic configure(input logic [ADDR_W-1:0] first,
                           input logic [SIZE_W-1:0] size,
                           input logic [GUARD_W-1:0] guard,
                           input logic [CNT_W-1:0] blocks);
    wait_quiet();
    write_reg(REG_FIRST_ADDR, first);
    write_reg(REG_BLOCK_SIZE, ADDR_W'(size));
    write_reg(REG_GUARD, ADDR_W'(guard));
    write_reg(REG_BLOCKS, ADDR_W'(blocks));
  endtask

  // mostly block starts, some one past the end, off by one, or anywhere
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [63:0] idx;
    idx = 64'($urandom_range(0, live_blocks() + 1));
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return block_address(idx);
      6:                return block_address(idx) + 1;
      7:                return block_address(idx) - 1;
      8:                return pool_first - 1;
      default:          return $urandom;
    endcase
  endfunction

  // alloc and free of held blocks dominate, so the list keeps churning
  task automatic random_request();
    int unsigned       pick;
    int unsigned       slot;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(99);
    if (pick < 35) begin
      request(OP_ALLOC, $urandom);
    end else if (pick < 65) begin
      if (held_blocks.size() != 0 && $urandom_range(9) < 8) begin
        slot = $urandom_range(held_blocks.size() - 1);
        addr = held_blocks[slot];
        held_blocks.delete(slot);
      end else begin
        addr = pick_address();
      end
      request(OP_FREE, addr);
    end else if (pick < 80) begin
      request(OP_CHECK, pick_address());
    end else begin
      // find of a held block walks the whole list
      if (held_blocks.size() != 0 && $urandom_range(3) == 0)
        addr = held_blocks[$urandom_range(held_blocks.size() - 1)];
      else
        addr = pick_address();
      request(OP_FIND, addr);
    end
  endtask

  task automatic random_setting();
    logic [ADDR_W-1:0]  first;
    logic [SIZE_W-1:0]  size;
    logic [GUARD_W-1:0] guard;
    logic [CNT_W-1:0]   blocks;
    case ($urandom_range(3))
      0:       first = '0;
      1:       first = 32'hFFFF_FFFF - $urandom_range(4096);
      default: first = $urandom;
    endcase
    case ($urandom_range(4))
      0:       size = '0;
      1:       size = 16'hFFFF;
      2:       size = SIZE_W'($urandom_range(1, 64));
      default: size = SIZE_W'($urandom);
    endcase
    case ($urandom_range(3))
      0:       guard = '0;
      1:       guard = 8'hFF;
      default: guard = GUARD_W'($urandom);
    endcase
    // small pools most of the time so the list runs dry and refills
    case ($urandom_range(9))
      0:       blocks = '0;
      1:       blocks = 9'd256;
      2:       blocks = 9'h1FF;
      3:       blocks = CNT_W'($urandom);
      default: blocks = CNT_W'($urandom_range(1, 24));
    endcase
    configure(first, size, guard, blocks);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // registers as after reset: 256 blocks of 16 bytes from address zero
  task automatic test_reset_defaults();
    req_idle_pct = 0;
    rsp_stall_pct = 0;
    request(OP_ALLOC, '0);
    request(OP_ALLOC, 32'hFFFF_FFFF);
    request(OP_CHECK, 32'd15);            // inside a block
    request(OP_CHECK, 32'd4080);          // last block
    request(OP_CHECK, 32'd4096);          // one past the end
    request(OP_CHECK, 32'hFFFF_FFFF);
    request(OP_FREE, 32'd16);             // back in front of the list
    request(OP_FREE, 32'd17);             // not a block start
    request(OP_FIND, 32'd16);
    request(OP_FIND, 32'd0);              // allocated, not in the list
    request(OP_FIND, 32'd32);
    request(OP_FIND, 32'd4080);           // deep in the list
    wait_quiet();
  endtask

  task automatic test_register_extremes();
    req_idle_pct = 0;
    rsp_stall_pct = 0;
    // zero size, widest guard, first block near the top so block one wraps
    configure(32'hFFFF_FFF0, 16'd0, 8'hFF, 9'd2);
    request(OP_ALLOC, '0);
    request(OP_ALLOC, '0);
    request(OP_ALLOC, '0);                        // pool empty
    request(OP_FREE, 32'hFFFF_FFF0 + 32'd511);    // wrapped, below first block
    request(OP_FREE, 32'hFFFF_FFF0);
    request(OP_FREE, 32'hFFFF_FFF0);              // double free
    request(OP_FIND, 32'hFFFF_FFF0);
    // zero block count leaves the pool empty
    configure('0, 16'hFFFF, 8'hFF, 9'd0);
    request(OP_ALLOC, '0);
    request(OP_FREE, '0);
    request(OP_CHECK, '0);
    // count above the pool depth, widest stride
    configure(32'h1000, 16'hFFFF, 8'hFF, 9'h1FF);
    request(OP_CHECK, 32'h1000 + 32'd255 * 32'd66045);
    request(OP_CHECK, 32'h1000 + 32'd256 * 32'd66045);   // end is exclusive
    request(OP_FIND, 32'h1000 + 32'd255 * 32'd66045);    // last list position
    request(OP_ALLOC, '0);
    wait_quiet();
  endtask

  // long receiver hold-off while items keep coming, so the block backs up
  task automatic test_backpressure();
    req_idle_pct = 0;
    rsp_stall_pct = 0;
    configure($urandom, SIZE_W'($urandom_range(1, 64)), GUARD_W'($urandom), 9'd8);
    hold_requests++;
    repeat (40) random_request();
    wait_quiet();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    req_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    repeat (3) begin
      random_setting();
      repeat (100) random_request();
    end
    wait_quiet();
  endtask

  initial begin
    pool_first = RST_FIRST_ADDR;
    pool_size = RST_BLOCK_SIZE;
    pool_guard = RST_GUARD;
    pool_blocks = RST_BLOCKS;
    rebuild_free_list();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_register_extremes();
    test_backpressure();
    test_random_traffic(0, 0);
    test_random_traffic(77, 0);
    test_random_traffic(0, 77);
    test_random_traffic(15, 15);

    wait_quiet();
    if (mismatch_count == 0 && pending_responses.size() == 0)
      $display("** fixed_block_pool_allocator: PASSED **");
    else
      $display("** fixed_block_pool_allocator: FAILED **");
    $finish;
  end

endmodule
